### rtl/core/thermistor_table_interpolator_assert.svh
// Assertion macros used by the thermistor table interpolator top level.
`ifndef THERMISTOR_TABLE_INTERPOLATOR_ASSERT_SVH
`define THERMISTOR_TABLE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define TTI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tti: assertion failed");
// Condition must never be true outside reset.
`define TTI_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tti: forbidden condition seen");
`else
`define TTI_ASSERT(lbl, clk, rst_n, prop)
`define TTI_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/core/tti_pkg.sv
// Package with the calibration ROM, widths and shared types of the interpolator.
package tti_pkg;

    localparam int ROM_POINTS        = 21;
    localparam int TABLE_ENTRIES_DEF = 21;
    localparam int IDX_W             = $clog2(ROM_POINTS + 1);
    localparam int SAMPLE_W          = 12;
    localparam int TEMP_W            = 11;
    // Largest temperature step between neighbors is 930, largest voltage step 327.
    localparam int DT_W              = 10;
    localparam int A_W               = 9;
    localparam int PROD_W            = DT_W + A_W;
    localparam int Q_W               = 10;
    // Reciprocals are exact for any product below 2**PROD_W with an error term below 2**A_W.
    localparam int RCP_SHIFT         = PROD_W + A_W;
    localparam int RCP_W             = 23;
    localparam int FULL_W            = PROD_W + RCP_W;

    localparam longint unsigned RCP_ONE = 64'd1 << RCP_SHIFT;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -11'sd100;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 11'sd1000;

    localparam logic [SAMPLE_W-1:0] ROM_MV [ROM_POINTS] = '{
        12'd1800, 12'd1577, 12'd1524, 12'd1463, 12'd1396, 12'd1322, 12'd1243,
        12'd1159, 12'd1073, 12'd986,  12'd900,  12'd816,  12'd736,  12'd660,
        12'd590,  12'd526,  12'd468,  12'd416,  12'd369,  12'd327,  12'd0
    };

    localparam logic signed [TEMP_W-1:0] ROM_TEMP [ROM_POINTS] = '{
        -11'sd100, -11'sd20, -11'sd15, -11'sd10, -11'sd5, 11'sd0,  11'sd5,
        11'sd10,   11'sd15,  11'sd20,  11'sd25,  11'sd30, 11'sd35, 11'sd40,
        11'sd45,   11'sd50,  11'sd55,  11'sd60,  11'sd65, 11'sd70, 11'sd1000
    };

    // Rounded-up reciprocal of the voltage span of the segment that ends at each point.
    localparam logic [RCP_W-1:0] ROM_RCP [ROM_POINTS] = '{
        '0,
        RCP_W'((RCP_ONE + ROM_MV[0] - ROM_MV[1] - 1) / (RCP_ONE * 0 + ROM_MV[0] - ROM_MV[1])),
        RCP_W'((RCP_ONE + ROM_MV[1] - ROM_MV[2] - 1) / (RCP_ONE * 0 + ROM_MV[1] - ROM_MV[2])),
        RCP_W'((RCP_ONE + ROM_MV[2] - ROM_MV[3] - 1) / (RCP_ONE * 0 + ROM_MV[2] - ROM_MV[3])),
        RCP_W'((RCP_ONE + ROM_MV[3] - ROM_MV[4] - 1) / (RCP_ONE * 0 + ROM_MV[3] - ROM_MV[4])),
        RCP_W'((RCP_ONE + ROM_MV[4] - ROM_MV[5] - 1) / (RCP_ONE * 0 + ROM_MV[4] - ROM_MV[5])),
        RCP_W'((RCP_ONE + ROM_MV[5] - ROM_MV[6] - 1) / (RCP_ONE * 0 + ROM_MV[5] - ROM_MV[6])),
        RCP_W'((RCP_ONE + ROM_MV[6] - ROM_MV[7] - 1) / (RCP_ONE * 0 + ROM_MV[6] - ROM_MV[7])),
        RCP_W'((RCP_ONE + ROM_MV[7] - ROM_MV[8] - 1) / (RCP_ONE * 0 + ROM_MV[7] - ROM_MV[8])),
        RCP_W'((RCP_ONE + ROM_MV[8] - ROM_MV[9] - 1) / (RCP_ONE * 0 + ROM_MV[8] - ROM_MV[9])),
        RCP_W'((RCP_ONE + ROM_MV[9] - ROM_MV[10] - 1) / (RCP_ONE * 0 + ROM_MV[9] - ROM_MV[10])),
        RCP_W'((RCP_ONE + ROM_MV[10] - ROM_MV[11] - 1) / (RCP_ONE * 0 + ROM_MV[10] - ROM_MV[11])),
        RCP_W'((RCP_ONE + ROM_MV[11] - ROM_MV[12] - 1) / (RCP_ONE * 0 + ROM_MV[11] - ROM_MV[12])),
        RCP_W'((RCP_ONE + ROM_MV[12] - ROM_MV[13] - 1) / (RCP_ONE * 0 + ROM_MV[12] - ROM_MV[13])),
        RCP_W'((RCP_ONE + ROM_MV[13] - ROM_MV[14] - 1) / (RCP_ONE * 0 + ROM_MV[13] - ROM_MV[14])),
        RCP_W'((RCP_ONE + ROM_MV[14] - ROM_MV[15] - 1) / (RCP_ONE * 0 + ROM_MV[14] - ROM_MV[15])),
        RCP_W'((RCP_ONE + ROM_MV[15] - ROM_MV[16] - 1) / (RCP_ONE * 0 + ROM_MV[15] - ROM_MV[16])),
        RCP_W'((RCP_ONE + ROM_MV[16] - ROM_MV[17] - 1) / (RCP_ONE * 0 + ROM_MV[16] - ROM_MV[17])),
        RCP_W'((RCP_ONE + ROM_MV[17] - ROM_MV[18] - 1) / (RCP_ONE * 0 + ROM_MV[17] - ROM_MV[18])),
        RCP_W'((RCP_ONE + ROM_MV[18] - ROM_MV[19] - 1) / (RCP_ONE * 0 + ROM_MV[18] - ROM_MV[19])),
        RCP_W'((RCP_ONE + ROM_MV[19] - ROM_MV[20] - 1) / (RCP_ONE * 0 + ROM_MV[19] - ROM_MV[20]))
    };

    typedef struct packed {
        logic signed [TEMP_W-1:0] base;
        logic [DT_W-1:0]          dt;
        logic [A_W-1:0]           a;
        logic [RCP_W-1:0]         recip;
    } t_seg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] base;
        logic [Q_W-1:0]           q;
    } t_quo;

    typedef struct packed {
        logic mul;
        logic rcp;
    } t_scale_en;

endpackage

### rtl/core/tti_compare.sv
// First stage: compares the sample against every table voltage at once.
module tti_compare
    import tti_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [SAMPLE_W-1:0]   i_sample_mv,
    output logic [ROM_POINTS-1:0] o_below,
    output logic [SAMPLE_W-1:0]   o_sample_mv
);

    localparam int USED = (TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS :
                          (TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES;

    logic [ROM_POINTS-1:0] n_below;
    logic [ROM_POINTS-1:0] r_below;
    logic [SAMPLE_W-1:0]   r_sample_mv;

    always_comb begin
        for (int k = 0; k < ROM_POINTS; k++) begin
            n_below[k] = (k < USED) && (ROM_MV[k] < i_sample_mv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_below     <= n_below;
            r_sample_mv <= i_sample_mv;
        end
    end

    assign o_below     = r_below;
    assign o_sample_mv = r_sample_mv;

endmodule

### rtl/core/tti_segment.sv
// Second stage: picks the segment and fetches its base, slope terms and reciprocal.
module tti_segment
    import tti_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ROM_POINTS-1:0] i_below,
    input  logic [SAMPLE_W-1:0]   i_sample_mv,
    output t_seg                  o_seg
);

    localparam int USED = (TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS :
                          (TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES;

    logic [IDX_W-1:0]         sel;
    logic [IDX_W-1:0]         prev;
    logic signed [TEMP_W-1:0] diff_t;
    logic [SAMPLE_W-1:0]      diff_v;
    t_seg                     n_seg;
    t_seg                     r_seg;

    // Lowest index whose voltage lies below the sample; USED when there is none.
    always_comb begin
        sel = IDX_W'(USED);
        for (int k = ROM_POINTS - 1; k >= 0; k--) begin
            if (i_below[k]) begin
                sel = IDX_W'(k);
            end
        end
    end

    always_comb begin
        prev   = sel - IDX_W'(1);
        diff_t = ROM_TEMP[sel] - ROM_TEMP[prev];
        diff_v = ROM_MV[prev] - i_sample_mv;
        priority if (sel == '0) begin
            n_seg.base  = ROM_TEMP[0];
            n_seg.dt    = '0;
            n_seg.a     = '0;
            n_seg.recip = '0;
        end else if (sel == IDX_W'(USED)) begin
            n_seg.base  = ROM_TEMP[IDX_W'(USED - 1)];
            n_seg.dt    = '0;
            n_seg.a     = '0;
            n_seg.recip = '0;
        end else begin
            n_seg.base  = ROM_TEMP[prev];
            n_seg.dt    = DT_W'(diff_t);
            n_seg.a     = A_W'(diff_v);
            n_seg.recip = ROM_RCP[sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

### rtl/core/tti_scale.sv
// Third and fourth stages: slope product, then division by reciprocal multiply.
module tti_scale
    import tti_pkg::*;
(
    input  logic      i_clk,
    input  t_scale_en i_en,
    input  t_seg      i_seg,
    output t_quo      o_quo
);

    logic signed [TEMP_W-1:0] r_base;
    logic [PROD_W-1:0]        r_prod;
    logic [RCP_W-1:0]         r_recip;
    logic [FULL_W-1:0]        full;
    t_quo                     n_quo;
    t_quo                     r_quo;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_base  <= i_seg.base;
            r_prod  <= PROD_W'(i_seg.dt) * PROD_W'(i_seg.a);
            r_recip <= i_seg.recip;
        end
    end

    always_comb begin
        full       = FULL_W'(r_prod) * FULL_W'(r_recip);
        n_quo.base = r_base;
        n_quo.q    = full[RCP_SHIFT +: Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rcp) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

### rtl/core/thermistor_table_interpolator.sv
// Top level of the thermistor table interpolator: handshake, stage valids and output adder.
//
// A word on the input channel is one 12-bit sample in millivolts; a word on the
// output channel is the matching 11-bit signed temperature. Both channels use
// valid and stall: a word moves at a rising edge where valid is high and stall low.
// The block is a five-stage pipeline: parallel compare against all table voltages,
// segment select and ROM fetch, slope multiply, reciprocal multiply that stands in
// for the divide by the segment span, and the final add with the output register.
// A sample passes the compare, segment, slope, reciprocal and output registers in turn,
// and one sample can enter every cycle while the receiver does not hold the full pipeline
// with its stall; the two multiplier stages set the clock period.
// Each stage carries a valid bit. A stage loads whenever it is empty or the stage
// after it moves, so bubbles collapse and a stalled result stays in place while
// earlier stages keep filling. The input side is stalled only once all five stages
// hold words and the receiver keeps stalling. Synchronous reset clears the valid
// bits only; the data registers keep their contents and the block is ready right after reset.
`include "thermistor_table_interpolator_assert.svh"

module thermistor_table_interpolator
    import tti_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [SAMPLE_W-1:0]      i_sample_mv,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [TEMP_W-1:0] o_temperature
);

    localparam int NSTG = 5;

    logic [NSTG-1:0]          r_v;
    logic [NSTG-1:0]          n_v;
    logic [NSTG-1:0]          en;
    logic [ROM_POINTS-1:0]    below;
    logic [SAMPLE_W-1:0]      sample_s1;
    t_seg                     seg;
    t_quo                     quo;
    t_scale_en                scale_en;
    logic signed [TEMP_W-1:0] n_temp;
    logic signed [TEMP_W-1:0] r_temp;

    // A stage may load when it is empty or its word leaves this cycle.
    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_comb begin
        n_v[0] = en[0] ? i_valid : r_v[0];
        for (int k = 1; k < NSTG; k++) begin
            n_v[k] = en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    tti_compare #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_compare (
        .i_clk       (i_clk),
        .i_en        (en[0]),
        .i_sample_mv (i_sample_mv),
        .o_below     (below),
        .o_sample_mv (sample_s1)
    );

    tti_segment #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_segment (
        .i_clk       (i_clk),
        .i_en        (en[1]),
        .i_below     (below),
        .i_sample_mv (sample_s1),
        .o_seg       (seg)
    );

    assign scale_en.mul = en[2];
    assign scale_en.rcp = en[3];

    tti_scale u_scale (
        .i_clk (i_clk),
        .i_en  (scale_en),
        .i_seg (seg),
        .o_quo (quo)
    );

    // The quotient is never negative, so it joins the base zero-extended.
    assign n_temp = quo.base + $signed(TEMP_W'(quo.q));

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_temp <= n_temp;
        end
    end

    assign o_stall       = !en[0];
    assign o_valid       = r_v[NSTG-1];
    assign o_temperature = r_temp;

    // Input back-pressure only arises when every stage is full and the output is held.
    `TTI_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (&r_v) && i_stall)
    // An accepted word always lands in the first stage.
    `TTI_ASSERT(a_enter, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_v[0])
    // Every result lies within the temperature span of the table.
    `TTI_NEVER(a_range, i_clk, i_rst_n, o_valid && (r_temp < TEMP_MIN || r_temp > TEMP_MAX))

endmodule

### tb/thermistor_table_interpolator_test.sv
// Self-checking testbench for the thermistor table interpolator.
module thermistor_table_interpolator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tti_pkg::*;

    // Table length given to the block; the predictor clamps it the same way.
    localparam int TABLE_LEN    = 21;
    // Idle cycles on both channels before the watchdog gives up.
    localparam int STUCK_LIMIT  = 1000;
    // Length of the long receiver hold-off that backs the pipeline up.
    localparam int HOLD_CYCLES  = 64;
    // Settle time after the last result; the pipeline is five stages deep.
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_WORDS = 1900;
    localparam int CHUNK_WORDS  = 100;

    // Temperature expectations for accepted samples, oldest first.
    // The predictor walks the calibration points from the top, finds the first
    // voltage strictly below the sample and interpolates from the point above it toward it.
    class temperature_book;
        logic signed [TEMP_W-1:0] pending_temps[$];
        int errors;
        int samples;
        int results;
        int above_table;
        int below_table;
        int on_point;
        int between_points;

        function int pending();
            return pending_temps.size();
        endfunction

        task report(input string msg);
            errors++;
            // Cap the printout so a badly broken block cannot flood the log.
            if (errors <= 30)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        function logic signed [TEMP_W-1:0] interpolate_temp(input int mv);
            int used;
            int k;
            int v_hi;
            int t_hi;
            int span;
            int rise;
            used = (TABLE_LEN > ROM_POINTS) ? ROM_POINTS : ((TABLE_LEN < 1) ? 1 : TABLE_LEN);
            k = 0;
            while (k < used && !(int'(ROM_MV[k]) < mv))
                k++;
            if (k == 0) begin
                above_table++;
                return ROM_TEMP[0];
            end
            if (k == used) begin
                below_table++;
                return ROM_TEMP[used-1];
            end
            v_hi = int'(ROM_MV[k-1]);
            t_hi = int'(ROM_TEMP[k-1]);
            span = int'(ROM_MV[k]) - v_hi;
            rise = int'(ROM_TEMP[k]) - t_hi;
            if (mv == v_hi)
                on_point++;
            else
                between_points++;
            // A flat segment cannot come from this table, but it would hold the upper point.
            if (span == 0)
                return TEMP_W'(t_hi);
            // Both operands are negative or zero here; SV division truncates toward zero.
            return TEMP_W'((rise * (mv - v_hi)) / span + t_hi);
        endfunction

        function void note_sample(input logic [SAMPLE_W-1:0] mv);
            samples++;
            pending_temps.push_back(interpolate_temp(int'(mv)));
        endfunction

        task check_temperature(input logic signed [TEMP_W-1:0] temp);
            logic signed [TEMP_W-1:0] want;
            results++;
            if (pending_temps.size() == 0) begin
                report($sformatf("temperature %0d arrived with no sample outstanding", temp));
            end else begin
                want = pending_temps.pop_front();
                if (temp !== want)
                    report($sformatf("temperature %0d, expected %0d", temp, want));
            end
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [SAMPLE_W-1:0]      i_sample_mv;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [TEMP_W-1:0] o_temperature;

    temperature_book book = new();

    // Idle shaping, one flag for the sender and one for the receiver. A quiet side never
    // waits, which gives stretches where a word moves on every edge.
    bit sender_quiet;
    bit receiver_quiet;
    // Raised by the main sequence to ask the receiver for one long hold-off.
    bit hold_request;
    int stuck_cycles;

    thermistor_table_interpolator #(
        .TABLE_ENTRIES(TABLE_LEN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_mv   (i_sample_mv),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_temperature (o_temperature)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // All checking happens at the rising edge, before any register in the block
    // has taken its new value. A sample is noted before a result is checked so
    // that the order would hold even for a block without latency.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                book.note_sample(i_sample_mv);
            if (o_valid && !i_stall)
                book.check_temperature(o_temperature);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
                $display("thermistor_table_interpolator_test: done, errors");
                $finish;
            end
        end
    end

    // Offer one sample word after a drawn gap and hold it until it is taken.
    // The task always returns at a falling edge, so back-to-back words keep
    // valid high without lowering it in between.
    task automatic send_sample(input logic [SAMPLE_W-1:0] mv);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_sample_mv = mv;
        do
            @(posedge i_clk);
        while (o_stall);
        @(negedge i_clk);
    endtask

    // Random sample, weighted toward the populated part of the table and toward
    // the breakpoints themselves, where off-by-one compares would show.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 4095);
            1, 2: begin
                v = int'(ROM_MV[$urandom_range(0, ROM_POINTS - 1)]) + $urandom_range(0, 4) - 2;
                if (v < 0)
                    v = 0;
            end
            default: v = $urandom_range(0, 1900);
        endcase
        return SAMPLE_W'(v);
    endfunction

    // Receiver: stalls for a drawn number of cycles before each result, and
    // once on request for a long stretch so that the pipeline fills and the
    // block has to stall its input.
    initial begin
        int wait_cycles;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end
            wait_cycles = receiver_quiet ? 0 : $urandom_range(0, 19);
            if (wait_cycles > 0) begin
                i_stall = 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do
                @(posedge i_clk);
            while (!o_valid && !hold_request);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [SAMPLE_W-1:0] corner_mv[$];
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_sample_mv    = '0;
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        hold_request   = 1'b0;
        stuck_cycles   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words: full scale and all-ones, alternating bit patterns,
        // samples just above, on and just below the top point, a few samples
        // that hit breakpoints exactly, the bottom segment and zero.
        corner_mv = '{12'd4095, 12'd2730, 12'd1365, 12'd1801, 12'd1800, 12'd1799,
                      12'd1578, 12'd1577, 12'd1576, 12'd1322, 12'd986,  12'd900,
                      12'd660,  12'd369,  12'd328,  12'd327,  12'd326,  12'd1,
                      12'd0};
        foreach (corner_mv[i])
            send_sample(corner_mv[i]);

        // The sender pauses until the pipeline has fully drained.
        i_valid = 1'b0;
        while (book.pending() > 0)
            @(negedge i_clk);

        // Long receiver hold-off while words keep coming back to back.
        hold_request = 1'b1;
        sender_quiet = 1'b1;
        repeat (30)
            send_sample(pick_sample());
        sender_quiet = 1'b0;

        // Random traffic in chunks, each with its own idle pattern per side.
        for (int c = 0; c < RANDOM_WORDS / CHUNK_WORDS; c++) begin
            sender_quiet   = (c == 3) || ($urandom_range(0, 3) == 0);
            receiver_quiet = (c == 3) || ($urandom_range(0, 3) == 0);
            repeat (CHUNK_WORDS)
                send_sample(pick_sample());
        end
        i_valid        = 1'b0;
        receiver_quiet = 1'b0;

        while (book.pending() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("summary: %0d samples, %0d temperatures checked, %0d mismatches",
                 book.samples, book.results, book.errors);
        $display("summary: %0d above the table, %0d below it, %0d on a point, %0d between",
                 book.above_table, book.below_table, book.on_point, book.between_points);
        if (book.errors == 0 && book.pending() == 0)
            $display("thermistor_table_interpolator_test: done, clean");
        else
            $display("thermistor_table_interpolator_test: done, errors");
        $finish;
    end

endmodule
